/* src/hphs_pkg.sv */
// types, codes and helper functions for the heat press hold sequencer
// no dependencies; used by every module of the block
package hphs_pkg;

  localparam int TEMP_W    = 21;
  localparam int ELAPSED_W = 10;
  localparam int HOLD_W    = 16;
  localparam int TARGET_W  = 9;
  localparam int COUNT_W   = 7;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_DW     = 32;
  localparam int IN_UW     = 2;
  localparam int OUT_DW    = 24;

  localparam int WINDOW_DEG    = 5;
  localparam int MILLI_PER_DEG = 1000;
  localparam int BLINK_TICKS   = 100;
  localparam int BLINK_PERIOD  = 20;
  localparam int BLINK_ON      = 10;

  // request kinds
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_PRESS   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_RESTART = 2'd3;

  // reported state codes
  localparam logic [2:0] CS_HEATING = 3'd0;
  localparam logic [2:0] CS_READY   = 3'd1;
  localparam logic [2:0] CS_FUSING  = 3'd2;
  localparam logic [2:0] CS_SUCCESS = 3'd3;
  localparam logic [2:0] CS_FAIL    = 3'd4;

  // register indexes
  localparam logic REG_TARGET_TEMP = 1'b0;
  localparam logic REG_HOLD_MS     = 1'b1;

  typedef enum logic [4:0] {
    ST_HEATING = 5'b00001,
    ST_READY   = 5'b00010,
    ST_FUSING  = 5'b00100,
    ST_SUCCESS = 5'b01000,
    ST_FAIL    = 5'b10000
  } run_state_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_temp;
    logic [HOLD_W-1:0]   hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [TEMP_W-1:0]  temp_milli;
    logic [ELAPSED_W-1:0]      elapsed_ms;
  } item_t;

  typedef struct packed {
    run_state_t           run_state;
    logic [HOLD_W-1:0]    hold_elapsed;
    logic                 press_latched;
    logic                 release_latched;
    logic [COUNT_W-1:0]   status_count;
  } seq_state_t;

  typedef struct packed {
    logic [2:0]        cur_state;
    logic              status_visible;
    logic [HOLD_W-1:0] hold_time;
    logic              ready_chirp;
    logic              success_tone;
    logic              fail_tone;
  } result_t;

  function automatic logic [2:0] state_code(input run_state_t st);
    logic [2:0] code;
    case (st)
      ST_HEATING: code = CS_HEATING;
      ST_READY:   code = CS_READY;
      ST_FUSING:  code = CS_FUSING;
      ST_SUCCESS: code = CS_SUCCESS;
      ST_FAIL:    code = CS_FAIL;
      default:    code = CS_HEATING;
    endcase
    return code;
  endfunction

  // blink phase: on while (shown mod period) < on time, as a set of range checks
  function automatic logic blink_on(input logic [COUNT_W-1:0] shown);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k * BLINK_PERIOD < (1 << COUNT_W); k++) begin
      if ({1'b0, shown} >= (COUNT_W+1)'(k * BLINK_PERIOD) &&
          {1'b0, shown} <  (COUNT_W+1)'(k * BLINK_PERIOD + BLINK_ON))
        hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

/* src/hphs_cfg_regs.sv */
// configuration register file on the apb-style port
// depends on hphs_pkg
module hphs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hphs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hphs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hphs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output hphs_pkg::cfg_t              cfg
);
  import hphs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register select on the word address bit
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[2])
        REG_TARGET_TEMP: cfg_nxt.target_temp = cfg_pwdata[TARGET_W-1:0];
        REG_HOLD_MS:     cfg_nxt.hold_ms     = cfg_pwdata[HOLD_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_TARGET_TEMP: cfg_prdata = CFG_DW'(cfg_r.target_temp);
      REG_HOLD_MS:     cfg_prdata = CFG_DW'(cfg_r.hold_ms);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* src/hphs_step.sv */
// next-state and result logic for one item of the sequencer
// depends on hphs_pkg
module hphs_step (
  input  hphs_pkg::cfg_t       cfg,
  input  hphs_pkg::item_t      item,
  input  hphs_pkg::seq_state_t cur,
  output hphs_pkg::seq_state_t nxt,
  output hphs_pkg::result_t    res
);
  import hphs_pkg::*;

  logic signed [TARGET_W+1:0] lo_deg;
  logic signed [23:0]         lo_ext;
  logic signed [23:0]         lo_milli;
  logic signed [23:0]         hi_milli;
  logic signed [23:0]         temp_ext;
  logic                       in_win;
  logic [HOLD_W:0]            hold_sum;
  logic [COUNT_W-1:0]         shown;
  logic                       chirp;
  logic                       succ;
  logic                       fail;

  // window test without a divider: truncated degrees compared through
  // millidegree thresholds, lower bound loosened by 999 when it is not positive
  assign lo_deg   = $signed({2'b00, cfg.target_temp}) - (TARGET_W+2)'(WINDOW_DEG);
  assign lo_ext   = 24'(lo_deg);
  assign lo_milli = (lo_deg > 0) ? 24'(lo_ext * 24'sd1000)
                                 : 24'(lo_ext * 24'sd1000) - 24'sd999;
  assign hi_milli = 24'($signed({15'd0, cfg.target_temp}) + 24'sd5) * 24'sd1000
                    + 24'sd999;
  assign temp_ext = 24'(item.temp_milli);
  assign in_win   = (temp_ext >= lo_milli) && (temp_ext <= hi_milli);

  assign hold_sum = {1'b0, cur.hold_elapsed} + (HOLD_W+1)'(item.elapsed_ms);

  always_comb begin
    nxt   = cur;
    chirp = 1'b0;
    succ  = 1'b0;
    fail  = 1'b0;
    case (item.req_type)
      REQ_PRESS: begin
        nxt.press_latched = 1'b1;
      end
      REQ_RELEASE: begin
        nxt.release_latched = 1'b1;
      end
      default: begin
        if (item.req_type == REQ_RESTART)
          nxt.run_state = ST_HEATING;
        case (nxt.run_state)
          ST_HEATING: begin
            if (in_win) begin
              nxt.run_state     = ST_READY;
              nxt.press_latched = 1'b0;
              chirp             = 1'b1;
            end
          end
          ST_READY: begin
            if (!in_win) begin
              nxt.run_state = ST_HEATING;
            end else if (cur.press_latched) begin
              nxt.release_latched = 1'b0;
              nxt.hold_elapsed    = '0;
              nxt.run_state       = ST_FUSING;
            end
          end
          ST_FUSING: begin
            if (cur.release_latched) begin
              nxt.status_count = '0;
              nxt.run_state    = ST_FAIL;
              fail             = 1'b1;
            end else if (cur.hold_elapsed >= cfg.hold_ms) begin
              nxt.status_count = '0;
              nxt.run_state    = ST_SUCCESS;
              succ             = 1'b1;
            end else if (hold_sum[HOLD_W]) begin
              nxt.hold_elapsed = '1;
            end else begin
              nxt.hold_elapsed = hold_sum[HOLD_W-1:0];
            end
          end
          ST_SUCCESS, ST_FAIL: begin
            if (cur.status_count >= COUNT_W'(BLINK_TICKS)) begin
              nxt.run_state     = ST_READY;
              nxt.press_latched = 1'b0;
              chirp             = 1'b1;
            end else begin
              nxt.status_count = cur.status_count + 1'b1;
            end
          end
          default: begin
            nxt.run_state = ST_HEATING;
          end
        endcase
      end
    endcase
  end

  assign shown = (nxt.status_count != '0) ? nxt.status_count - 1'b1 : '0;

  always_comb begin
    res.cur_state      = state_code(nxt.run_state);
    res.status_visible = (nxt.run_state == ST_SUCCESS || nxt.run_state == ST_FAIL)
                         ? blink_on(shown) : 1'b1;
    res.hold_time      = nxt.hold_elapsed;
    res.ready_chirp    = chirp;
    res.success_tone   = succ;
    res.fail_tone      = fail;
  end

endmodule

/* src/heat_press_hold_sequencer_core.sv */
// heat press hold sequencer: one result item for every input item
// an accepted item passes the input register, then the result register, before its result is valid
// throughput: 1 item per cycle while the result channel does not stall; the state update is a single pass of hphs_step
// a full result register that is not taken (out_tready low) stalls the input register, which stalls in_tready
// reset (rst_n low, synchronous): state heating, hold time 0, latches and
// blink count clear, both channels empty; item and result data are not reset
module heat_press_hold_sequencer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [20:0] temp_milli, [30:21] elapsed_ms, [31] zero
  input  logic [hphs_pkg::IN_DW-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [hphs_pkg::IN_UW-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [2:0] cur_state, [3] status_visible, [19:4] hold_time, [20] ready_chirp,
  // [21] success_tone, [22] fail_tone, [23] zero
  output logic [hphs_pkg::OUT_DW-1:0] out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [hphs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [hphs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [hphs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import hphs_pkg::*;

  cfg_t       cfg;
  item_t      item_r;
  logic       item_vld_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    res_nxt;
  result_t    res_r;
  logic       out_vld_r;
  logic       advance;

  hphs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hphs_step u_step (
    .cfg  (cfg),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  assign advance   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.req_type   <= in_tuser[1:0];
      item_r.temp_milli <= in_tdata[TEMP_W-1:0];
      item_r.elapsed_ms <= in_tdata[TEMP_W+ELAPSED_W-1:TEMP_W];
    end
  end

  // sequencer state moves once per item, when its result is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.run_state       <= ST_HEATING;
      state_r.hold_elapsed    <= '0;
      state_r.press_latched   <= 1'b0;
      state_r.release_latched <= 1'b0;
      state_r.status_count    <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, res_r.fail_tone, res_r.success_tone, res_r.ready_chirp,
                       res_r.hold_time, res_r.status_visible, res_r.cur_state};

endmodule

/* src/hphs_checker.sv */
// port-level checks for the heat press hold sequencer, bound to the top level
// depends on hphs_pkg and heat_press_hold_sequencer_core
module hphs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [hphs_pkg::OUT_DW-1:0] out_tdata
);
  import hphs_pkg::*;

  // result channel empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  // at most one event flag per item
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[22:20]))
    else $error("more than one event flag");

  // each event flag matches the state it announces
  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[20] || out_tdata[2:0] == CS_READY) &&
                   (!out_tdata[21] || out_tdata[2:0] == CS_SUCCESS) &&
                   (!out_tdata[22] || out_tdata[2:0] == CS_FAIL))
    else $error("event flag does not match state");

  // status text blinks only in success or fail
  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != CS_SUCCESS && out_tdata[2:0] != CS_FAIL
    |-> out_tdata[3])
    else $error("status hidden outside success or fail");

endmodule

bind heat_press_hold_sequencer_core hphs_checker u_hphs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/tb_heat_press_hold_sequencer_core.sv */
// self-checking bench for heat_press_hold_sequencer_core: tick and switch items go in through
// a bursty driver, results are checked against an in-bench sequencer predictor
// depends on hphs_pkg and the core
module tb_heat_press_hold_sequencer_core;
  import hphs_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // [20:0] temp_milli, [30:21] elapsed_ms, [31] zero
  logic [IN_DW-1:0]    in_tdata = '0;
  // [1:0] req_type
  logic [IN_UW-1:0]    in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // [2:0] cur_state, [3] status_visible, [19:4] hold_time, [20] ready_chirp,
  // [21] success_tone, [22] fail_tone, [23] zero
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  heat_press_hold_sequencer_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and sequencer state
  logic [TARGET_W-1:0] target_q = '0;
  logic [HOLD_W-1:0]   hold_ms_q = '0;
  logic [2:0]          seq_st = CS_HEATING;
  logic [HOLD_W-1:0]   hold_acc = '0;
  logic                press_l = 1'b0;
  logic                release_l = 1'b0;
  logic [COUNT_W-1:0]  blink_cnt = '0;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      n_queued = 0;
  int      n_sent = 0;
  int      mismatches = 0;
  logic    in_taken = 1'b0;

  task automatic press_step(input logic [1:0] req, input logic signed [TEMP_W-1:0] temp,
                            input logic [ELAPSED_W-1:0] el, output result_t r);
    int         t;
    int         deg;
    int         diff;
    int         sum;
    logic       ok;
    logic       chirp;
    logic       succ;
    logic       fl;
    logic [COUNT_W-1:0] shown;
    chirp = 1'b0;
    succ  = 1'b0;
    fl    = 1'b0;
    if (req == REQ_PRESS) begin
      press_l = 1'b1;
    end else if (req == REQ_RELEASE) begin
      release_l = 1'b1;
    end else begin
      t    = temp;
      deg  = t / MILLI_PER_DEG;
      diff = int'(target_q) - deg;
      ok   = (diff <= WINDOW_DEG) && (diff >= -WINDOW_DEG);
      if (req == REQ_RESTART) seq_st = CS_HEATING;
      case (seq_st)
        CS_HEATING: begin
          if (ok) begin
            seq_st  = CS_READY;
            press_l = 1'b0;
            chirp   = 1'b1;
          end
        end
        CS_READY: begin
          if (!ok) begin
            seq_st = CS_HEATING;
          end else if (press_l) begin
            release_l = 1'b0;
            hold_acc  = '0;
            seq_st    = CS_FUSING;
          end
        end
        CS_FUSING: begin
          // release wins over a reached hold time
          if (release_l) begin
            blink_cnt = '0;
            seq_st    = CS_FAIL;
            fl        = 1'b1;
          end else if (hold_acc >= hold_ms_q) begin
            blink_cnt = '0;
            seq_st    = CS_SUCCESS;
            succ      = 1'b1;
          end else begin
            sum = int'(hold_acc) + int'(el);
            hold_acc = (sum > 65535) ? 16'hFFFF : HOLD_W'(sum);
          end
        end
        CS_SUCCESS, CS_FAIL: begin
          if (blink_cnt >= BLINK_TICKS) begin
            seq_st  = CS_READY;
            press_l = 1'b0;
            chirp   = 1'b1;
          end else begin
            blink_cnt = blink_cnt + 1'b1;
          end
        end
        default: seq_st = CS_HEATING;
      endcase
    end
    shown = (blink_cnt != 0) ? blink_cnt - 1'b1 : '0;
    r.cur_state = seq_st;
    if (seq_st == CS_SUCCESS || seq_st == CS_FAIL)
      r.status_visible = (int'(shown) % BLINK_PERIOD) < BLINK_ON;
    else
      r.status_visible = 1'b1;
    r.hold_time    = hold_acc;
    r.ready_chirp  = chirp;
    r.success_tone = succ;
    r.fail_tone    = fl;
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    item_t it;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, it.elapsed_ms, it.temp_milli};
        in_tuser  <= it.req_type;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: its own stall pattern plus a periodic long hold-off
  int rx_cycles = 0;
  int rx_mode = 0;
  int hold_off = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycles++;
      if (rx_cycles % 1000 == 300) hold_off = 80;
      if (rx_cycles % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_off > 0) begin
        hold_off--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= rx_cycles[0];
        endcase
      end
    end
  end

  // monitor: predict on input accept, check on result accept
  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    logic    taken;
    if (rst_n) begin
      taken = in_tvalid && in_tready;
      in_taken <= taken;
      if (out_tvalid && out_tready) begin
        got.cur_state      = out_tdata[2:0];
        got.status_visible = out_tdata[3];
        got.hold_time      = out_tdata[19:4];
        got.ready_chirp    = out_tdata[20];
        got.success_tone   = out_tdata[21];
        got.fail_tone      = out_tdata[22];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: state %0d vis %0b hold %0d flags %0b%0b%0b",
                     got.cur_state, got.status_visible, got.hold_time,
                     got.ready_chirp, got.success_tone, got.fail_tone);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected state %0d vis %0b hold %0d flags %0b%0b%0b",
                       exp_r.cur_state, exp_r.status_visible, exp_r.hold_time,
                       exp_r.ready_chirp, exp_r.success_tone, exp_r.fail_tone);
              $display("          got      state %0d vis %0b hold %0d flags %0b%0b%0b",
                       got.cur_state, got.status_visible, got.hold_time,
                       got.ready_chirp, got.success_tone, got.fail_tone);
            end
          end
        end
      end
      if (taken) begin
        press_step(in_tuser, in_tdata[20:0], in_tdata[30:21], exp_r);
        expected_results.push_back(exp_r);
        n_sent++;
      end
    end
  end

  task automatic add_item(input logic [1:0] req, input int temp, input int el);
    item_t it;
    it.req_type   = req;
    it.temp_milli = temp[TEMP_W-1:0];
    it.elapsed_ms = el[ELAPSED_W-1:0];
    pending_items.push_back(it);
    n_queued++;
  endtask

  task automatic wait_idle;
    while (n_sent != n_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx) << 2;
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_TARGET_TEMP) target_q = value[TARGET_W-1:0];
    else hold_ms_q = value[HOLD_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic int temp_in_window();
    return int'(target_q) * 1000 + int'($urandom_range(0, 10998)) - 4999;
  endfunction

  function automatic int temp_near_edge();
    return int'(target_q) * 1000 + int'($urandom_range(0, 17998)) - 8999;
  endfunction

  function automatic int temp_any();
    return int'($urandom_range(0, 2097151)) - 1048576;
  endfunction

  // heat up, press, fuse with an optional early release, then blink back to ready
  task automatic queue_press_cycle(input int elmin, input int elmax, input int fuse_max);
    int n_fuse;
    int rel_at;
    repeat ($urandom_range(0, 2)) add_item(REQ_TICK, temp_any(), $urandom_range(0, 1023));
    repeat ($urandom_range(1, 3)) add_item(REQ_TICK, temp_in_window(), $urandom_range(0, 1023));
    add_item(REQ_PRESS, temp_any(), $urandom_range(0, 1023));
    add_item(REQ_TICK, temp_in_window(), $urandom_range(0, 1023));
    n_fuse = $urandom_range(1, fuse_max);
    rel_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_fuse) : -1;
    for (int i = 0; i < n_fuse; i++) begin
      if (i == rel_at) add_item(REQ_RELEASE, temp_any(), $urandom_range(0, 1023));
      add_item(REQ_TICK, ($urandom_range(0, 3) == 0) ? temp_any() : temp_in_window(),
               $urandom_range(elmin, elmax));
    end
    repeat ($urandom_range(95, 106)) begin
      if ($urandom_range(0, 40) == 0) add_item(REQ_PRESS, temp_any(), $urandom_range(0, 1023));
      add_item(REQ_TICK, temp_in_window(), $urandom_range(0, 1023));
    end
  endtask

  task automatic run_phase(input int tgt, input int hold, input int n,
                           input int elmin, input int elmax, input int fuse_max);
    int start;
    int pick;
    wait_idle();
    cfg_write(REG_TARGET_TEMP, tgt);
    cfg_write(REG_HOLD_MS, hold);
    start = n_queued;
    while (n_queued - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        queue_press_cycle(elmin, elmax, fuse_max);
      end else if (pick <= 7) begin
        repeat ($urandom_range(1, 8))
          add_item(2'($urandom_range(0, 3)), temp_any(), $urandom_range(0, 1023));
      end else if (pick == 8) begin
        add_item(REQ_RESTART, temp_near_edge(), $urandom_range(0, 1023));
      end else begin
        repeat ($urandom_range(2, 10))
          add_item(REQ_TICK, temp_near_edge(), $urandom_range(0, 1023));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait_idle();
    cfg_write(REG_TARGET_TEMP, 200);
    cfg_write(REG_HOLD_MS, 500);
    // field extremes and window edges, starting in heating
    add_item(REQ_TICK, 0, 0);
    add_item(REQ_TICK, -1048576, 1023);
    add_item(REQ_TICK, 1048575, 0);
    add_item(REQ_TICK, 194999, 5);
    add_item(REQ_TICK, 195000, 5);
    add_item(REQ_TICK, 205999, 5);
    add_item(REQ_TICK, 206000, 5);
    // a press in heating is dropped on entry to ready
    add_item(REQ_PRESS, 0, 0);
    add_item(REQ_TICK, 200000, 0);
    add_item(REQ_TICK, 200000, 0);
    // a release before the press is cleared on entry to fusing
    add_item(REQ_RELEASE, 0, 0);
    add_item(REQ_PRESS, 0, 0);
    add_item(REQ_TICK, 200000, 0);
    add_item(REQ_TICK, 200000, 300);
    add_item(REQ_TICK, 0, 300);
    add_item(REQ_TICK, 200000, 1023);
    add_item(REQ_TICK, 200000, 0);
    add_item(REQ_RELEASE, 0, 0);
    add_item(REQ_RESTART, 200000, 0);
    add_item(REQ_PRESS, 0, 0);
    add_item(REQ_TICK, 201000, 0);
    add_item(REQ_RELEASE, 0, 0);
    add_item(REQ_TICK, 201000, 100);
    add_item(REQ_RESTART, 0, 0);
    add_item(REQ_TICK, -1000, 0);

    run_phase(200, 500, 200, 0, 1023, 8);
    run_phase(0, 0, 200, 0, 1023, 4);
    run_phase(500, 60000, 320, 700, 1023, 100);
    run_phase(511, 65535, 320, 800, 1023, 110);
    run_phase($urandom_range(0, 511), $urandom_range(0, 5000), 200, 0, 1023, 20);
    run_phase($urandom_range(0, 511), $urandom_range(0, 65535), 200, 0, 1023, 30);

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
src/hphs_pkg.sv
src/hphs_cfg_regs.sv
src/hphs_step.sv
src/heat_press_hold_sequencer_core.sv
src/hphs_checker.sv
bench/tb_heat_press_hold_sequencer_core.sv
